[design/longest_window_within_range_top_macros.svh]
// Assertion macros for the longest-window-within-range block.
// Used by the top level only; expects i_clk and i_rst_n in scope.
`ifndef LONGEST_WINDOW_WITHIN_RANGE_TOP_MACROS_SVH
`define LONGEST_WINDOW_WITHIN_RANGE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define LWR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define LWR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/lwr_pkg.sv]
// Shared constants and types for the longest-window-within-range block.
// No dependencies.
package lwr_pkg;

    localparam int MAX_LEN_DEF      = 1024;
    localparam int SAMPLE_WIDTH_DEF = 32;

    localparam int SAMPLE_PORT_W = 32;   // sample field on the input stream
    localparam int LIMIT_W       = 31;   // range_limit register
    localparam int LEN_W         = 11;   // window_len / best_len fields
    localparam int OUT_DATA_W    = 24;   // two length fields, padded to bytes

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP_RD,
        ST_POP_CMP,
        ST_PUSH,
        ST_SHR_RD,
        ST_SHR_CMP,
        ST_DONE
    } t_state;

endpackage

[design/lwr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// Standalone; no package needed.
module lwr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/longest_window_within_range_top.sv]
// Longest window within range: top level, control sequencer and deque pointers.
// Depends on lwr_pkg, lwr_ram and longest_window_within_range_top_macros.svh.
//
// Samples arrive on the s_axis stream: tdata carries the signed sample, tuser
// the first-of-sequence flag, which clears the deques, window and best length
// before the sample is taken. Each request yields one result on m_axis: window
// length, best length so far and an overflow flag (sample ignored, sequence
// already holds MAX_LEN samples). range_limit is written through the cfg
// channel, always ready; write it only while no sample is in flight.
// Each deque (max and min) lives in one RAM with a registered read.
// A sample runs the sequencer through its tail pop rounds (both deques pop in
// the same round), one push, then the left steps of the window; a step that
// moves a deque head waits for a new head read. The result is loaded in the
// final state; an overflowed sample skips to it. The input is taken only
// when idle; a new sample may be taken while the last result still waits in
// the output register. If the receiver stalls, the next result waits in the
// final state. Reset (i_rst_n low, synchronous) empties the sequence and
// clears the limit to 0; RAM contents are not cleared and need not be.
module longest_window_within_range_top
    import lwr_pkg::*;
#(
    parameter int MAX_LEN      = MAX_LEN_DEF,
    parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration write channel
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [LIMIT_W-1:0]       i_cfg_data,      // range_limit
    // sample stream
    input  logic                     i_s_axis_tvalid,
    output logic                     o_s_axis_tready,
    input  logic [SAMPLE_PORT_W-1:0] i_s_axis_tdata,  // [31:0] sample (signed)
    input  logic [0:0]               i_s_axis_tuser,  // [0] first
    // result stream
    output logic                     o_m_axis_tvalid,
    input  logic                     i_m_axis_tready,
    output logic [OUT_DATA_W-1:0]    o_m_axis_tdata,  // [10:0] window_len, [21:11] best_len
    output logic [0:0]               o_m_axis_tuser   // [0] overflow
);

    localparam int IDX_W  = $clog2(MAX_LEN);
    localparam int CNT_W  = $clog2(MAX_LEN + 1);
    localparam int SUM_W  = IDX_W + 1;
    localparam int ENT_W  = SAMPLE_WIDTH + IDX_W;
    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int CMP_W  = (DIFF_W > LIMIT_W) ? DIFF_W : LIMIT_W;
    localparam logic [SUM_W-1:0] DEPTH_S = SUM_W'(MAX_LEN);
    localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(MAX_LEN);

    // head + offset, offset below the depth, folded into the ring
    function automatic logic [IDX_W-1:0] f_wrap(input logic [SUM_W-1:0] s);
        f_wrap = (s >= DEPTH_S) ? IDX_W'(s - DEPTH_S) : IDX_W'(s);
    endfunction

    t_state r_state, n_state;

    logic [LIMIT_W-1:0]      r_limit;
    logic [SAMPLE_WIDTH-1:0] r_v;
    logic                    r_ovf;
    logic [IDX_W-1:0]        r_max_head, r_min_head, r_left;
    logic [CNT_W-1:0]        r_max_cnt, r_min_cnt, r_next, r_best;
    logic                    r_max_act, r_min_act;
    logic                    r_out_valid, r_out_ovf;
    logic [LEN_W-1:0]        r_out_win, r_out_best;

    logic [SAMPLE_WIDTH-1:0] in_v;
    logic                    s_accept, ovf_now, out_load;
    logic [ENT_W-1:0]        max_rd, min_rd, wr_ent;
    logic [SAMPLE_WIDTH-1:0] max_val, min_val;
    logic [IDX_W-1:0]        max_idx, min_idx, right;
    logic [IDX_W-1:0]        max_tail, min_tail, max_push, min_push, max_next, min_next;
    logic [IDX_W-1:0]        max_raddr, min_raddr;
    logic                    ram_we, max_pop, min_pop, shrink, pop_max_head, pop_min_head;
    logic [DIFF_W-1:0]       diff;
    logic [CNT_W-1:0]        len;

    // sample field: when narrowed, the sign lives in bit SAMPLE_WIDTH-1; a wider field is zero-extended
    generate
        if (SAMPLE_WIDTH <= SAMPLE_PORT_W) begin : g_narrow
            assign in_v = i_s_axis_tdata[SAMPLE_WIDTH-1:0];
        end else begin : g_wide
            assign in_v = {{(SAMPLE_WIDTH - SAMPLE_PORT_W){1'b0}}, i_s_axis_tdata};
        end
    endgenerate

    assign max_val = max_rd[SAMPLE_WIDTH-1:0];
    assign max_idx = max_rd[ENT_W-1:SAMPLE_WIDTH];
    assign min_val = min_rd[SAMPLE_WIDTH-1:0];
    assign min_idx = min_rd[ENT_W-1:SAMPLE_WIDTH];
    assign right   = r_next[IDX_W-1:0];
    assign wr_ent  = {right, r_v};

    assign max_tail = f_wrap({1'b0, r_max_head} + SUM_W'(r_max_cnt) - SUM_W'(1));
    assign min_tail = f_wrap({1'b0, r_min_head} + SUM_W'(r_min_cnt) - SUM_W'(1));
    assign max_push = f_wrap({1'b0, r_max_head} + SUM_W'(r_max_cnt));
    assign min_push = f_wrap({1'b0, r_min_head} + SUM_W'(r_min_cnt));
    assign max_next = f_wrap({1'b0, r_max_head} + SUM_W'(1));
    assign min_next = f_wrap({1'b0, r_min_head} + SUM_W'(1));

    assign diff = {max_val[SAMPLE_WIDTH-1], max_val} - {min_val[SAMPLE_WIDTH-1], min_val};
    assign len  = r_next - CNT_W'(r_left) + CNT_W'(1);

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;
    assign ovf_now  = !i_s_axis_tuser[0] && (r_next >= FULL_C);
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_m_axis_tready);

    lwr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LEN)) u_max_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (max_push),
        .i_wdata (wr_ent),
        .i_raddr (max_raddr),
        .o_rdata (max_rd)
    );

    lwr_ram #(.WIDTH(ENT_W), .DEPTH(MAX_LEN)) u_min_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (min_push),
        .i_wdata (wr_ent),
        .i_raddr (min_raddr),
        .o_rdata (min_rd)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_accept) begin
                    n_state = ovf_now ? ST_DONE : ST_POP_RD;
                end
            end
            ST_POP_RD:  n_state = (r_max_act || r_min_act) ? ST_POP_CMP : ST_PUSH;
            ST_POP_CMP: n_state = ST_POP_RD;
            ST_PUSH:    n_state = ST_SHR_RD;
            ST_SHR_RD:  n_state = ST_SHR_CMP;
            ST_SHR_CMP: begin
                if (!shrink) begin
                    n_state = ST_DONE;
                end else if (pop_max_head || pop_min_head) begin
                    n_state = ST_SHR_RD;   // a head moved, wait for the new read
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_s_axis_tready = (r_state == ST_IDLE);
        ram_we          = (r_state == ST_PUSH);
        max_raddr       = max_tail;
        min_raddr       = min_tail;
        max_pop         = 1'b0;
        min_pop         = 1'b0;
        shrink          = 1'b0;
        pop_max_head    = 1'b0;
        pop_min_head    = 1'b0;
        unique case (r_state)
            ST_POP_CMP: begin
                max_pop = r_max_act && ($signed(max_val) <= $signed(r_v));
                min_pop = r_min_act && ($signed(r_v) <= $signed(min_val));
            end
            ST_SHR_RD: begin
                max_raddr = r_max_head;
                min_raddr = r_min_head;
            end
            ST_SHR_CMP: begin
                max_raddr    = r_max_head;
                min_raddr    = r_min_head;
                shrink       = (CMP_W'(diff) > CMP_W'(r_limit)) && (r_left <= right);
                pop_max_head = shrink && (max_idx == r_left);
                pop_min_head = shrink && (min_idx == r_left);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_limit     <= '0;
            r_ovf       <= 1'b0;
            r_max_head  <= '0;
            r_min_head  <= '0;
            r_max_cnt   <= '0;
            r_min_cnt   <= '0;
            r_left      <= '0;
            r_next      <= '0;
            r_best      <= '0;
            r_max_act   <= 1'b0;
            r_min_act   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (s_accept) begin
                r_v   <= in_v;
                r_ovf <= ovf_now;
                if (i_s_axis_tuser[0]) begin
                    r_max_head <= '0;
                    r_min_head <= '0;
                    r_max_cnt  <= '0;
                    r_min_cnt  <= '0;
                    r_left     <= '0;
                    r_next     <= '0;
                    r_best     <= '0;
                    r_max_act  <= 1'b0;
                    r_min_act  <= 1'b0;
                end else begin
                    r_max_act <= (r_max_cnt != '0);
                    r_min_act <= (r_min_cnt != '0);
                end
            end
            if (r_state == ST_POP_CMP) begin
                // a deque keeps popping while the tail is dominated and not empty
                r_max_act <= max_pop && (r_max_cnt > CNT_W'(1));
                r_min_act <= min_pop && (r_min_cnt > CNT_W'(1));
                if (max_pop) begin
                    r_max_cnt <= r_max_cnt - CNT_W'(1);
                end
                if (min_pop) begin
                    r_min_cnt <= r_min_cnt - CNT_W'(1);
                end
            end
            if (ram_we) begin
                r_max_cnt <= r_max_cnt + CNT_W'(1);
                r_min_cnt <= r_min_cnt + CNT_W'(1);
            end
            if (shrink) begin
                r_left <= r_left + IDX_W'(1);
                if (pop_max_head) begin
                    r_max_head <= max_next;
                    r_max_cnt  <= r_max_cnt - CNT_W'(1);
                end
                if (pop_min_head) begin
                    r_min_head <= min_next;
                    r_min_cnt  <= r_min_cnt - CNT_W'(1);
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                if (!r_ovf) begin
                    r_next <= r_next + CNT_W'(1);
                    if (len > r_best) begin
                        r_best <= len;
                    end
                end
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_ovf  <= r_ovf;
            r_out_win  <= r_ovf ? '0 : LEN_W'(len);
            r_out_best <= (!r_ovf && (len > r_best)) ? LEN_W'(len) : LEN_W'(r_best);
        end
    end

    assign o_cfg_ready     = 1'b1;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{(OUT_DATA_W - 2 * LEN_W){1'b0}}, r_out_best, r_out_win};
    assign o_m_axis_tuser  = r_out_ovf;

`include "longest_window_within_range_top_macros.svh"

    `LWR_ASSERT_NEXT(a_accept_leaves_idle, s_accept, r_state != ST_IDLE,
        "request taken but sequencer stayed idle")
    `LWR_ASSERT_NOW(a_result_from_done, $rose(o_m_axis_tvalid), $past(r_state) == ST_DONE,
        "result loaded outside final state")
    `LWR_ASSERT_NOW(a_left_within_seq, r_state == ST_IDLE, CNT_W'(r_left) <= r_next,
        "window left beyond sequence end")
    `LWR_ASSERT_NOW(a_win_not_above_best, (MAX_LEN < 2048) && r_out_valid && !r_out_ovf,
        r_out_win <= r_out_best, "window length above best length")

endmodule
